/* hw/rtl/sobel_edge_magnitude_3x3_macros.svh */
// Assertion helpers for the Sobel edge block.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SEM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SEM_ASSERT_IMP(label, clk, rst, ante, cons)
`define SEM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/sem_pkg.sv */
package sem_pkg;
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = 12;
   localparam int WID_W = 11;
   localparam int MAG_W = 11;
   localparam int SQ_W = 22;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic CSR_WIDTH = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_DONE} sqrt_state_type;

   // front phases: ready, line store read pending, multiply, holding item
   typedef enum logic [1:0] {FR_IDLE, FR_READ, FR_MULT, FR_HOLD} front_phase_type;

   // front-to-back work item
   typedef struct packed {
      logic [SQ_W-1:0] sumsq;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic last;
   } work_type;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [COL_W-1:0] center_col;
      logic [ROW_W-1:0] center_row;
      logic last;
   } rsp_type;
endpackage

/* hw/rtl/sem_req_if.sv */
interface sem_req_if;
   logic valid;
   logic ready;
   logic [7:0] gray;
   logic frame_start;
   modport source (output valid, gray, frame_start, input ready);
   modport sink (input valid, gray, frame_start, output ready);
endinterface

/* hw/rtl/sem_rsp_if.sv */
interface sem_rsp_if;
   logic valid;
   logic ready;
   logic [10:0] magnitude;
   logic [9:0] center_col;
   logic [11:0] center_row;
   logic last;
   modport source (output valid, magnitude, center_col, center_row, last, input ready);
   modport sink (input valid, magnitude, center_col, center_row, last, output ready);
endinterface

/* hw/rtl/sem_ram.sv */
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input logic clock,
   input logic we,
   input logic [$clog2(DEPTH)-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule

/* hw/rtl/sem_front.sv */
// Front: position tracking, line stores, window, gradients, sum of squares.
// One pixel per call: accept (read issue), window update, interior-only multiply.
module sem_front import sem_pkg::*; (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic csr_index,
   input logic [ROW_W-1:0] csr_wdata,
   input logic in_valid,
   output logic in_ready,
   input logic [7:0] in_gray,
   input logic in_frame_start,
   output logic out_valid,
   input logic out_ready,
   output work_type out_item
);
   logic [WID_W-1:0] width_ff;
   logic [ROW_W-1:0] height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [7:0] win_ff [6];
   front_phase_type ph_ff, ph_in;
   logic [7:0] gray_ff;
   logic [COL_W-1:0] c_ff;
   logic [ROW_W-1:0] r_ff;
   logic emit_ff, last_ff;
   logic [7:0] up_q, mid_q;
   logic signed [10:0] gx_ff, gy_ff;
   work_type item_ff;
   logic acc;

   logic [WID_W-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [COL_W-1:0] c_cur;
   logic [ROW_W-1:0] r_cur;
   logic [WID_W:0] cw;
   logic signed [10:0] gx_c, gy_c;
   logic [9:0] ax, ay;

   always_comb begin
      w_eff = width_ff < WID_W'(3) ? WID_W'(3) :
              (width_ff > WID_W'(MAX_WIDTH) ? WID_W'(MAX_WIDTH) : width_ff);
      h_eff = height_ff < ROW_W'(3) ? ROW_W'(3) : height_ff;
      c_cur = in_frame_start ? '0 : col_ff;
      r_cur = in_frame_start ? '0 : row_ff;
      cw = {1'b0, WID_W'(c_cur)} + (WID_W+1)'(1);
      if (cw >= {1'b0, w_eff}) begin
         col_in = '0;
         row_in = (r_cur + ROW_W'(1) >= h_eff || r_cur == '1) ? '0 : r_cur + ROW_W'(1);
      end else begin
         col_in = c_cur + COL_W'(1);
         row_in = r_cur;
      end
   end

   assign in_ready = (ph_ff == FR_IDLE);
   assign acc = in_valid && in_ready;

   always_comb begin
      ph_in = ph_ff;
      case (ph_ff)
         FR_IDLE: if (acc) ph_in = FR_READ;
         FR_READ: ph_in = emit_ff ? FR_MULT : FR_IDLE;
         FR_MULT: ph_in = FR_HOLD;
         FR_HOLD: if (out_ready) ph_in = FR_IDLE;
         default: ph_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) ph_ff <= FR_IDLE;
      else ph_ff <= ph_in;
   end

   sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_up (
      .clock(clock), .we(ph_ff == FR_READ), .waddr(c_ff), .wdata(mid_q),
      .raddr(c_cur), .rdata(up_q));
   sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid (
      .clock(clock), .we(ph_ff == FR_READ), .waddr(c_ff), .wdata(gray_ff),
      .raddr(c_cur), .rdata(mid_q));

   always_comb begin
      gx_c = 11'(signed'({3'b0, win_ff[0]})) + 11'(signed'({2'b0, win_ff[1], 1'b0}))
           + 11'(signed'({3'b0, win_ff[2]})) - 11'(signed'({3'b0, up_q}))
           - 11'(signed'({2'b0, mid_q, 1'b0})) - 11'(signed'({3'b0, gray_ff}));
      gy_c = 11'(signed'({3'b0, win_ff[0]})) + 11'(signed'({2'b0, win_ff[3], 1'b0}))
           + 11'(signed'({3'b0, up_q})) - 11'(signed'({3'b0, win_ff[2]}))
           - 11'(signed'({2'b0, win_ff[5], 1'b0})) - 11'(signed'({3'b0, gray_ff}));
      ax = gx_ff[10] ? 10'(-gx_ff) : 10'(gx_ff);
      ay = gy_ff[10] ? 10'(-gy_ff) : 10'(gy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WID_W'(640);
         height_ff <= ROW_W'(480);
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WIDTH: width_ff <= csr_wdata[WID_W-1:0];
               CSR_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (ph_ff)
            FR_IDLE: if (acc) begin
               gray_ff <= in_gray;
               c_ff <= c_cur;
               r_ff <= r_cur;
               emit_ff <= (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
               last_ff <= (r_cur == h_eff - ROW_W'(1)) &&
                          ({1'b0, WID_W'(c_cur)} == {1'b0, w_eff} - (WID_W+1)'(1));
               col_ff <= col_in;
               row_ff <= row_in;
            end
            FR_READ: begin
               gx_ff <= gx_c;
               gy_ff <= gy_c;
               win_ff[0] <= win_ff[3];
               win_ff[1] <= win_ff[4];
               win_ff[2] <= win_ff[5];
               win_ff[3] <= up_q;
               win_ff[4] <= mid_q;
               win_ff[5] <= gray_ff;
            end
            FR_MULT: begin
               item_ff.sumsq <= SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
               item_ff.col <= c_ff - COL_W'(1);
               item_ff.row <= r_ff - ROW_W'(1);
               item_ff.last <= last_ff;
            end
            default: ;
         endcase
      end
   end

   assign out_valid = (ph_ff == FR_HOLD);
   assign out_item = item_ff;
endmodule

/* hw/rtl/sem_queue.sv */
`include "sobel_edge_magnitude_3x3_macros.svh"
// Small FIFO between front and back.
module sem_queue import sem_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input work_type in_item,
   output logic out_valid,
   input logic out_ready,
   output work_type out_item
);
   work_type mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wp_ff, rp_ff;
   logic [QPTR_W:0] cnt_ff;
   logic push, pop;
   assign in_ready = cnt_ff != (QPTR_W+1)'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_item = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_item;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + QPTR_W'(1);
         if (pop) rp_ff <= rp_ff + QPTR_W'(1);
         cnt_ff <= cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end
   `SEM_ASSERT_IMP(a_no_overflow, clock, reset, cnt_ff == (QPTR_W+1)'(QDEPTH), !push)
   `SEM_ASSERT_NXT(a_cnt_up, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1)
   `SEM_ASSERT_IMP(a_empty_ptrs, clock, reset, cnt_ff == '0, wp_ff == rp_ff)
endmodule

/* hw/rtl/sem_back.sv */
// Back: bit-pair integer square root, one step a cycle, and output register.
module sem_back import sem_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input work_type in_item,
   output logic out_valid,
   input logic out_ready,
   output rsp_type out_rsp
);
   localparam int STEPS = SQ_W / 2;
   sqrt_state_type st_ff, st_in;
   logic [SQ_W-1:0] v_ff, v_in;
   logic [SQ_W-1:0] res_ff, res_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   work_type hold_ff;
   rsp_type rsp_ff;
   logic load, done_step;
   logic [SQ_W-1:0] trial;

   always_ff @(posedge clock) begin
      if (reset) st_ff <= SQ_IDLE;
      else st_ff <= st_in;
      v_ff <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (load) hold_ff <= in_item;
      if (done_step) begin
         rsp_ff.magnitude <= MAG_W'(res_in);
         rsp_ff.center_col <= hold_ff.col;
         rsp_ff.center_row <= hold_ff.row;
         rsp_ff.last <= hold_ff.last;
      end
   end

   always_comb begin
      st_in = st_ff;
      v_in = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      load = 1'b0;
      done_step = 1'b0;
      trial = res_ff + bit_ff;
      in_ready = (st_ff == SQ_IDLE);
      out_valid = (st_ff == SQ_DONE);
      case (st_ff)
         SQ_IDLE: if (in_valid) begin
            load = 1'b1;
            v_in = in_item.sumsq;
            res_in = '0;
            bit_in = SQ_W'(1) << (2 * (STEPS - 1));
            st_in = SQ_RUN;
         end
         SQ_RUN: begin
            if (v_ff >= trial) begin
               v_in = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == SQ_W'(1)) begin
               done_step = 1'b1;
               st_in = SQ_DONE;
            end
         end
         SQ_DONE: if (out_ready) st_in = SQ_IDLE;
         default: st_in = SQ_IDLE;
      endcase
   end
   assign out_rsp = rsp_ff;
endmodule

/* hw/rtl/sobel_edge_magnitude_3x3.sv */
// Streaming 3x3 Sobel edge magnitude. Pixels arrive in raster order on req_;
// each interior pixel yields one rsp_ transaction with floor(sqrt(Gx^2+Gy^2))
// and the window center position; border pixels yield none. Rate: the front
// takes a new pixel after a line store read and window update, plus multiply
// and handoff for interior pixels; the back root unit takes 11 steps plus
// load and handoff per result and sets the sustained rate for interior pixels.
// A 4-entry queue lets the two sides stall independently. No clearing pass:
// line stores are undefined until written. csr_index 0 = width, 1 = height.
module sobel_edge_magnitude_3x3 import sem_pkg::*; (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic csr_index,
   input logic [ROW_W-1:0] csr_wdata,
   sem_req_if.sink req,
   sem_rsp_if.source rsp
);
   logic f_valid, f_ready, q_valid, q_ready;
   work_type f_item, q_item;
   rsp_type r;

   sem_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .in_valid(req.valid), .in_ready(req.ready), .in_gray(req.gray),
      .in_frame_start(req.frame_start),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item));
   sem_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));
   sem_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(r));

   assign rsp.magnitude = r.magnitude;
   assign rsp.center_col = r.center_col;
   assign rsp.center_row = r.center_row;
   assign rsp.last = r.last;
endmodule
